/* rtl/core/epoch_seconds_to_calendar_unit_macros.svh */
// Assertion macros for the epoch-to-calendar converter.
// Used by the controller; no other dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ESC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/esc_pkg.sv */
// Shared types, constants and calendar functions of the epoch-to-calendar converter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package esc_pkg;

   // Field widths
   localparam int EpochWidth = 32;
   localparam int ZoneWidth  = 17;
   localparam int RemWidth   = 33;
   localparam int QuoWidth   = 16;
   localparam int DaysWidth  = 16;
   localparam int YearWidth  = 11;
   localparam int RspWidth   = 40;

   // Constants
   localparam logic [ZoneWidth-1:0] ZoneReset   = 17'd28800;
   localparam logic [16:0]          SecsPerDay  = 17'd86400;
   localparam logic [16:0]          SecsPerMin  = 17'd60;
   localparam logic [10:0]          MinsPerHour = 11'd60;
   localparam logic [YearWidth-1:0] EpochYear   = 11'd1970;
   // Whole days added so that the day division always sees a positive dividend
   localparam logic [QuoWidth-1:0]  BiasDays    = 16'd24856;
   localparam logic [33:0]          BiasSecs    = 34'd2147558400;

   // Reciprocals for the constant divisions once the power-of-two factor is
   // shifted out (86400 = 675 << 7, 60 = 15 << 2); exact over every value reached
   localparam logic [26:0] DayRecip  = 27'd101806633;  // ceil(2^36 / 675)
   localparam logic [15:0] MinRecip  = 16'd34953;      // ceil(2^19 / 15)
   localparam logic [9:0]  HourRecip = 10'd547;        // ceil(2^13 / 15)

   // Controller states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StDay    = 3'd1;
   localparam logic [2:0] StFix    = 3'd2;
   localparam logic [2:0] StHour   = 3'd3;
   localparam logic [2:0] StMin    = 3'd4;
   localparam logic [2:0] StYear   = 3'd5;
   localparam logic [2:0] StMonth  = 3'd6;
   localparam logic [2:0] StFinish = 3'd7;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic day_step;     // day quotient
      logic fix_days;     // day index and second of day
      logic hour_step;    // minute of day
      logic min_step;     // hour, and second of minute
      logic year_step;
      logic month_step;
      logic publish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic year_done;
      logic month_done;
   } sts_type;

   // Gregorian leap rule: centuries only when divisible by 400
   function automatic logic leap_year(input logic [YearWidth-1:0] y);
      logic century;
      century = 1'b0;
      for (int k = 1; k <= 20; k++) begin
         if ((y == 11'(k * 100)) && ((k % 4) != 0)) begin
            century = 1'b1;
         end
      end
      return (y[1:0] == 2'b00) && !century;
   endfunction

   function automatic logic [8:0] year_length(input logic [YearWidth-1:0] y);
      return leap_year(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_length(input logic [YearWidth-1:0] y,
                                               input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2: begin
            len = leap_year(y) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/epoch_seconds_to_calendar_unit.sv */
// Top level of the epoch-to-calendar converter: joins controller and datapath.
// Depends on esc_pkg, esc_controller and esc_datapath.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  req_tdata[31:0]  epoch seconds
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[39:0]  calendar fields
//   csr      in   csr_wr_en              csr_wr_data[16:0] zone offset
//
// One transaction at a time: from accept to result the unit runs the
// reciprocal-multiply divisions and then the year and month walks, one step
// per cycle.
// The next request is taken once the result sits in the output register.
// Synchronous active-high reset; the zone offset resets to +8 hours.
// A stalled result blocks only the hand-over of the following one.
`default_nettype none

module epoch_seconds_to_calendar_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // epoch_seconds[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cal_year[10:0], cal_month[14:11], cal_day[19:15], cal_hour[24:20],
   // cal_minute[30:25], cal_second[36:31], zero [39:37]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data  // zone_offset_seconds, signed
);

   esc_pkg::cmd_type cmd;
   esc_pkg::sts_type sts;

   // Sequencer
   esc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Arithmetic and result register
   esc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_tdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/esc_controller.sv */
// Sequencer of the epoch-to-calendar converter: steps the datapath through
// day division, time-of-day split, year walk and month walk. Uses esc_pkg.
`default_nettype none

module esc_controller (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire esc_pkg::sts_type sts,
   output esc_pkg::cmd_type     cmd
);

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_tready = (state_ff == esc_pkg::StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         esc_pkg::StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = esc_pkg::StDay;
            end
         end
         esc_pkg::StDay: begin
            cmd.day_step = 1'b1;
            state_in     = esc_pkg::StFix;
         end
         esc_pkg::StFix: begin
            cmd.fix_days = 1'b1;
            state_in     = esc_pkg::StHour;
         end
         esc_pkg::StHour: begin
            cmd.hour_step = 1'b1;
            state_in      = esc_pkg::StMin;
         end
         esc_pkg::StMin: begin
            cmd.min_step = 1'b1;
            state_in     = esc_pkg::StYear;
         end
         esc_pkg::StYear: begin
            if (sts.year_done) begin
               state_in = esc_pkg::StMonth;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         esc_pkg::StMonth: begin
            if (sts.month_done) begin
               state_in = esc_pkg::StFinish;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         esc_pkg::StFinish: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = esc_pkg::StIdle;
            end
         end
         default: begin
            state_in = esc_pkg::StIdle;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`include "epoch_seconds_to_calendar_unit_macros.svh"

   `ESC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.publish, !rsp_valid_ff || rsp_tready, "result overwritten before delivery")
   `ESC_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == esc_pkg::StDay, "accepted transaction did not start day division")
   `ESC_ASSERT_NEXT(a_year_holds, clock, reset, (state_ff == esc_pkg::StYear) && !sts.year_done, state_ff == esc_pkg::StYear, "year walk left early")
   `ESC_ASSERT_NEXT(a_month_holds, clock, reset, (state_ff == esc_pkg::StMonth) && !sts.month_done, state_ff == esc_pkg::StMonth, "month walk left early")

endmodule

`default_nettype wire

/* rtl/core/esc_datapath.sv */
// Datapath of the epoch-to-calendar converter: zone register, reciprocal-multiply
// dividers, year and month walkers, result register. Uses esc_pkg.
`default_nettype none

module esc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [esc_pkg::ZoneWidth-1:0]    csr_wr_data,
   input  wire logic [esc_pkg::EpochWidth-1:0]   req_data,
   input  wire esc_pkg::cmd_type                 cmd,
   output esc_pkg::sts_type                      sts,
   output logic [esc_pkg::RspWidth-1:0]          rsp_data
);

   logic [esc_pkg::ZoneWidth-1:0]        zone_ff;
   logic [esc_pkg::RemWidth-1:0]         rem_ff, rem_in;
   logic [esc_pkg::QuoWidth-1:0]         quo_ff, quo_in;
   logic signed [esc_pkg::DaysWidth-1:0] days_ff, days_in;
   logic [esc_pkg::YearWidth-1:0]        year_ff, year_in;
   logic [3:0]                           month_ff, month_in;
   logic [4:0]                           hour_ff, hour_in;
   logic [10:0]                          mins_ff, mins_in;
   logic [esc_pkg::RspWidth-1:0]         out_ff;

   logic [33:0]                          total;
   logic [52:0]                          day_prod;
   logic [32:0]                          day_base;
   logic [30:0]                          min_prod;
   logic [18:0]                          hour_prod;
   logic [16:0]                          mins_base;
   logic [10:0]                          hour_base;
   logic [10:0]                          minute_val;
   logic [esc_pkg::YearWidth-1:0]        prev_year;
   logic signed [esc_pkg::DaysWidth-1:0] cur_ylen, prev_ylen, cur_mlen;
   logic [4:0]                           day_of_month;

   // Zone offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= esc_pkg::ZoneReset;
      end else if (csr_wr_en) begin
         zone_ff <= csr_wr_data;
      end
   end

   // Biased local seconds, always positive
   assign total = 34'($signed(req_data)) + 34'($signed(zone_ff)) + esc_pkg::BiasSecs;

   // Constant divisions by reciprocal multiplication, one product per cycle
   assign day_prod  = rem_ff[32:7] * esc_pkg::DayRecip;     // seconds / 86400
   assign day_base  = quo_ff * esc_pkg::SecsPerDay;
   assign min_prod  = rem_ff[16:2] * esc_pkg::MinRecip;     // second of day / 60
   assign hour_prod = mins_ff[10:2] * esc_pkg::HourRecip;   // minute of day / 60
   assign mins_base = mins_ff * esc_pkg::SecsPerMin;
   assign hour_base = hour_ff * esc_pkg::MinsPerHour;

   // Calendar lengths
   assign prev_year = year_ff - 11'd1;
   assign cur_ylen  = $signed({7'd0, esc_pkg::year_length(year_ff)});
   assign prev_ylen = $signed({7'd0, esc_pkg::year_length(prev_year)});
   assign cur_mlen  = $signed({11'd0, esc_pkg::month_length(year_ff, month_ff)});

   assign sts.year_done  = !days_ff[esc_pkg::DaysWidth-1] && (days_ff < cur_ylen);
   assign sts.month_done = (month_ff == 4'd12) || (days_ff < cur_mlen);

   // Next values
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      hour_in  = hour_ff;
      mins_in  = mins_ff;
      if (cmd.load) begin
         rem_in   = total[esc_pkg::RemWidth-1:0];
         year_in  = esc_pkg::EpochYear;
         month_in = 4'd1;
      end
      if (cmd.day_step) begin
         quo_in = day_prod[51:36];
      end
      // Unbias the day count; what is left is the second of the day
      if (cmd.fix_days) begin
         days_in = $signed(quo_ff - esc_pkg::BiasDays);
         rem_in  = rem_ff - day_base;
      end
      if (cmd.hour_step) begin
         mins_in = min_prod[29:19];
      end
      // Hour of day, and second of minute left in the remainder
      if (cmd.min_step) begin
         hour_in = hour_prod[17:13];
         rem_in  = {16'd0, rem_ff[16:0] - mins_base};
      end
      // One year per step, backward while the day index is negative
      if (cmd.year_step) begin
         if (days_ff[esc_pkg::DaysWidth-1]) begin
            year_in = prev_year;
            days_in = days_ff + prev_ylen;
         end else begin
            year_in = year_ff + 11'd1;
            days_in = days_ff - cur_ylen;
         end
      end
      if (cmd.month_step) begin
         month_in = month_ff + 4'd1;
         days_in  = days_ff - cur_mlen;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      hour_ff  <= hour_in;
      mins_ff  <= mins_in;
   end

   // Result register: year, month, day, hour, minute, second from bit 0
   assign day_of_month = days_ff[4:0] + 5'd1;
   assign minute_val   = mins_ff - hour_base;
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff <= {3'd0, rem_ff[5:0], minute_val[5:0], hour_ff, day_of_month, month_ff,
                    year_ff};
      end
   end
   assign rsp_data = out_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_epoch_seconds_to_calendar_unit.sv */
// Self-checking testbench for the epoch-to-calendar converter: drives epoch seconds
// under several zone offsets and compares every calendar result with a local predictor.
// Depends on epoch_seconds_to_calendar_unit only.

module tb_epoch_seconds_to_calendar_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint      SecsPerDay = 86400;
   localparam longint      EpochYear  = 1970;
   localparam int unsigned CycleLimit = 1000000;
   localparam int          IdleCycles = 4;
   localparam int          TailCycles = 120;

   // One calendar result, field widths as on rsp_tdata
   typedef struct packed {
      logic [2:0]  pad;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [10:0] year;
   } cal_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   logic signed [16:0] zone_now = 17'sd28800;
   cal_rec_type        cal_expected[$];
   cal_rec_type        cal_head;
   cal_rec_type        cal_seen;
   logic               failed = 1'b0;
   logic               steady_flow = 1'b0;
   int                 ready_hold = 0;
   int unsigned        cycle_count = 0;

   epoch_seconds_to_calendar_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[epoch_seconds_to_calendar_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic is_leap(input longint yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic longint days_in_month(input longint yr, input longint mon);
      longint len;
      len = 31;
      if (mon == 2) begin
         len = is_leap(yr) ? 29 : 28;
      end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
         len = 30;
      end
      return len;
   endfunction

   // Local civil time for one epoch count under the given zone offset
   function automatic cal_rec_type civil_time(input logic signed [31:0] epoch,
                                              input logic signed [16:0] zone);
      longint      total;
      longint      day_idx;
      longint      sod;
      longint      yr;
      longint      mon;
      cal_rec_type rec;
      total   = longint'(epoch) + longint'(zone);
      day_idx = total / SecsPerDay;
      sod     = total % SecsPerDay;
      // floor division: negative sums belong to the earlier day
      if (sod < 0) begin
         sod     += SecsPerDay;
         day_idx -= 1;
      end
      yr = EpochYear;
      while (day_idx >= (is_leap(yr) ? 366 : 365)) begin
         day_idx -= is_leap(yr) ? 366 : 365;
         yr      += 1;
      end
      while (day_idx < 0) begin
         yr      -= 1;
         day_idx += is_leap(yr) ? 366 : 365;
      end
      mon = 1;
      while (mon < 12 && day_idx >= days_in_month(yr, mon)) begin
         day_idx -= days_in_month(yr, mon);
         mon     += 1;
      end
      rec.pad    = '0;
      rec.year   = yr[10:0];
      rec.month  = mon[3:0];
      rec.day    = 5'(day_idx + 1);
      rec.hour   = 5'(sod / 3600);
      rec.minute = 6'((sod % 3600) / 60);
      rec.second = 6'(sod % 60);
      return rec;
   endfunction

   // ---------------------------------------------------------------- checker

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cal_seen = rsp_tdata;
         if (cal_expected.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            cal_head = cal_expected.pop_front();
            check_field("cal_year",   cal_head.year,   cal_seen.year);
            check_field("cal_month",  cal_head.month,  cal_seen.month);
            check_field("cal_day",    cal_head.day,    cal_seen.day);
            check_field("cal_hour",   cal_head.hour,   cal_seen.hour);
            check_field("cal_minute", cal_head.minute, cal_seen.minute);
            check_field("cal_second", cal_head.second, cal_seen.second);
            check_field("tdata pad",  cal_head.pad,    cal_seen.pad);
         end
      end
   end

   // ---------------------------------------------------------------- flow control

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Result side back-pressure
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
         ready_hold <= pick_gap();
      end
   end

   // One request transaction; the expectation is queued on acceptance
   task automatic send_epoch(input logic [31:0] epoch);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= epoch;
      do @(posedge clock); while (!req_tready);
      cal_expected.push_back(civil_time(epoch, zone_now));
   endtask

   // Hold off until every result is back and the unit has gone idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (cal_expected.size() != 0) @(posedge clock);
      repeat (IdleCycles) @(posedge clock);
   endtask

   task automatic write_zone(input logic [16:0] offset);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= offset;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      zone_now = offset;
   endtask

   // Random epoch, biased towards the range ends, day edges and the epoch itself
   function automatic logic [31:0] pick_epoch();
      longint v;
      int     kind;
      kind = $urandom_range(0, 9);
      v    = longint'($signed($urandom));
      case (kind)
         6: begin
            if ($urandom_range(0, 1) != 0) begin
               v = -64'sd2147483648 + longint'($urandom_range(0, 200000));
            end else begin
               v = 64'sd2147483647 - longint'($urandom_range(0, 200000));
            end
         end
         7: begin
            // local midnight, give or take a couple of seconds
            v = (longint'($urandom_range(0, 49700)) - 24850) * SecsPerDay
                - longint'(zone_now) + longint'($urandom_range(0, 4)) - 2;
         end
         8: begin
            v = longint'($urandom_range(0, 400000)) - 200000;
         end
         default: begin
         end
      endcase
      if (v < -64'sd2147483648 || v > 64'sd2147483647) begin
         v = longint'($signed($urandom));
      end
      return v[31:0];
   endfunction

   // ---------------------------------------------------------------- tests

   // Reset value of the offset, around the epoch, the range ends and leap days
   task automatic test_reset_offset();
      send_epoch(32'd0);
      send_epoch(-32'sd1);
      send_epoch(32'd1);
      send_epoch(32'h7FFF_FFFF);
      send_epoch(32'h8000_0000);
      send_epoch(32'd951782400);   // leap day 2000, midnight UTC
      send_epoch(32'd951868799);
      send_epoch(32'd946684799);   // last second of 1999 UTC
      send_epoch(32'd68169600);
      send_epoch(32'd2145916800);
      send_epoch(-32'sd2145916800);
   endtask

   // Offsets well beyond real time zones, and a zero offset on negative sums
   task automatic test_zone_extremes();
      write_zone(17'h1_0000);
      send_epoch(32'h8000_0000);
      send_epoch(32'h7FFF_FFFF);
      send_epoch(32'd0);
      send_epoch(-32'sd1);
      write_zone(17'h0_FFFF);
      send_epoch(32'h8000_0000);
      send_epoch(32'h7FFF_FFFF);
      send_epoch(32'd0);
      send_epoch(-32'sd1);
      write_zone(17'd0);
      send_epoch(-32'sd1);
      send_epoch(-32'sd86400);
      send_epoch(-32'sd86401);
      send_epoch(32'd0);
      write_zone(17'(-50400));
      send_epoch(32'd0);
      write_zone(17'd50400);
      send_epoch(-32'sd1);
   endtask

   // Phases of random epochs, each under its own offset
   task automatic test_random_epochs();
      logic [16:0] offset;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       offset = 17'($urandom);
            1:       offset = 17'((int'($urandom_range(0, 112)) - 56) * 900);
            2:       offset = 17'h0_FFFF;
            3:       offset = 17'h1_0000;
            default: offset = 17'($urandom);
         endcase
         write_zone(offset);
         // last phase runs without gaps on either side
         steady_flow = (phase == 4);
         for (int n = 0; n < 100; n++) begin
            if (n == 50) begin
               settle();
            end
            send_epoch(pick_epoch());
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_offset();
      test_zone_extremes();
      test_random_epochs();
      settle();
      repeat (TailCycles) @(posedge clock);
      if (!failed) begin
         $display("[epoch_seconds_to_calendar_unit] OK");
      end else begin
         $display("[epoch_seconds_to_calendar_unit] ERROR");
      end
      $finish;
   end

endmodule
